FILE: rtl/core/gtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtm_pkg
// Shared types and constants of the greedy 2x2 tile merge unit.
// ----------------------------------------------------------------------------
package gtm_pkg;

  // Field widths fixed by the interface
  localparam int TYPE_W   = 8;
  localparam int DIM_W    = 9;
  localparam int SIZE_W   = 16;
  localparam int CFG_W    = 16;
  localparam int COORD_W  = 8;
  localparam int WORLD_W  = 25;
  localparam int EXTENT_W = 17;

  // Register reset values
  localparam logic [TYPE_W-1:0] RST_TARGET_TYPE = 8'd0;
  localparam logic [DIM_W-1:0]  RST_GRID_DIM    = 9'd256;
  localparam logic [SIZE_W-1:0] RST_TILE_SIZE   = 16'd100;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TARGET_TYPE = 2'd0,
    CFG_GRID_WIDTH  = 2'd1,
    CFG_GRID_HEIGHT = 2'd2,
    CFG_TILE_SIZE   = 2'd3
  } cfg_index_t;

  // Classification of one accepted tile, front to back
  typedef struct packed {
    logic match;      // tile equals the target type
    logic row_end;    // last column of the grid
    logic last_row;   // last row of the grid
    logic has_upper;  // a row above exists
    logic has_left;   // a column to the left exists
  } tile_class_t;

  // Match and visited bits of one cell
  typedef struct packed {
    logic m;
    logic v;
  } cell_bits_t;

  // Per-point tag travelling with the coordinates
  typedef struct packed {
    logic merged;
    logic last;
  } point_tag_t;

endpackage

FILE: rtl/core/gtm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtm_queue
// Two-entry queue between the classifier and the merge engine.
// ----------------------------------------------------------------------------
module gtm_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [DW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [DW-1:0] pop_data
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DW-1:0]    mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

FILE: rtl/core/gtm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtm_front
// Accepts tiles, tracks the raster position and classifies each tile.
// ----------------------------------------------------------------------------
module gtm_front #(
  parameter int CW = 8,
  parameter int RW = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  logic [gtm_pkg::TYPE_W-1:0] target_type,
  input  logic [CW-1:0]              wm1,
  input  logic [RW-1:0]              hm1,
  input  logic                       tile_valid,
  output logic                       tile_stall,
  input  logic [gtm_pkg::TYPE_W-1:0] tile_type,
  output logic                       push_valid,
  input  logic                       push_ready,
  output logic [CW-1:0]              col,
  output logic [RW-1:0]              row,
  output gtm_pkg::tile_class_t       cls
);

  import gtm_pkg::*;

  logic accept;

  assign tile_stall = !push_ready;
  assign push_valid = tile_valid;
  assign accept     = tile_valid && push_ready;

  // Classification of the tile at the current position
  always_comb begin
    cls.match     = (tile_type == target_type);
    cls.row_end   = (col == wm1);
    cls.last_row  = (row == hm1);
    cls.has_upper = (row != '0);
    cls.has_left  = (col != '0);
  end

  // Raster position; a geometry change restarts the grid
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (cls.row_end) begin
        col <= '0;
        row <= cls.last_row ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/gtm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtm_back
// Merge engine: row delay line of cell bits, per-tile decisions and the
// sequencer that hands out the resulting points one per cycle while pt_ready is high.
// ----------------------------------------------------------------------------
module gtm_back #(
  parameter int MAX_WIDTH = 256,
  parameter int CW        = 8,
  parameter int RW        = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CW-1:0]        wm1,
  input  logic                 ent_valid,
  output logic                 ent_ready,
  input  logic [CW-1:0]        ent_col,
  input  logic [RW-1:0]        ent_row,
  input  gtm_pkg::tile_class_t ent_cls,
  output logic                 pt_valid,
  input  logic                 pt_ready,
  output logic [CW-1:0]        pt_x,
  output logic [RW-1:0]        pt_y,
  output gtm_pkg::point_tag_t  pt_tag
);

  import gtm_pkg::*;

  localparam int LINE_N = MAX_WIDTH - 1;

  // Row state
  cell_bits_t line_q [LINE_N];
  cell_bits_t up_prev;   // upper row, column to the left
  cell_bits_t lo_prev;   // current row, column to the left
  cell_bits_t tap;       // upper row, current column
  cell_bits_t wr;        // finished cell entering the delay line

  // Decision terms
  logic       cand;
  logic       merge;
  logic       un_v1;
  logic       lx_v1;
  logic [3:0] new_mask;

  // Point sequencer
  logic [3:0]    ev_mask;
  logic [CW-1:0] ev_col;
  logic [RW-1:0] ev_row;
  logic          ev_large;
  logic [3:0]    pick;
  logic [3:0]    rem;
  logic          issue;
  logic          load;

  // Decisions for the tile at the queue head
  always_comb begin
    tap   = (wm1 == '0) ? lo_prev : line_q[0];
    cand  = ent_cls.has_upper && ent_cls.has_left && up_prev.m && !up_prev.v;
    merge = cand && tap.m && !tap.v && lo_prev.m && !lo_prev.v && ent_cls.match;
    un_v1 = tap.v | merge;
    lx_v1 = lo_prev.v | merge;
    // slot order: upper left, upper here, bottom left, bottom here
    new_mask[0] = cand;
    new_mask[1] = ent_cls.has_upper && ent_cls.row_end && tap.m && !un_v1;
    new_mask[2] = ent_cls.last_row && ent_cls.has_left && lo_prev.m && !lx_v1;
    new_mask[3] = ent_cls.last_row && ent_cls.row_end && ent_cls.match && !merge;
    wr.m = lo_prev.m;
    wr.v = lx_v1;
  end

  // Sequencer handshake
  always_comb begin
    pick      = ev_mask & (~ev_mask + 4'd1);
    rem       = ev_mask & ~pick;
    pt_valid  = (ev_mask != '0);
    issue     = pt_valid && pt_ready;
    ent_ready = (ev_mask == '0) || (issue && (rem == '0));
    load      = ent_valid && ent_ready;
  end

  // Point coordinates of the picked slot
  always_comb begin
    pt_x          = (pick[0] || pick[2]) ? ev_col - CW'(1) : ev_col;
    pt_y          = (pick[0] || pick[1]) ? ev_row - RW'(1) : ev_row;
    pt_tag.merged = pick[0] && ev_large;
    pt_tag.last   = (rem == '0);
  end

  // Pending points and neighbour bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_mask <= '0;
      up_prev <= '0;
      lo_prev <= '0;
    end else begin
      if (load) begin
        ev_mask <= new_mask;
        up_prev <= '{m: tap.m, v: un_v1};
        lo_prev <= '{m: ent_cls.match, v: merge};
      end else if (issue) begin
        ev_mask <= rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_col   <= ent_col;
      ev_row   <= ent_row;
      ev_large <= merge;
    end
  end

  // Delay line of width-1 cells; enters at the tap chosen by the width
  for (genvar i = 0; i < LINE_N; i++) begin : g_line
    if (i == LINE_N - 1) begin : g_tail
      always_ff @(posedge clk) begin
        if (load) line_q[i] <= wr;
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (load) begin
          if ((CW+1)'(i + 1) == {1'b0, wm1}) line_q[i] <= wr;
          else line_q[i] <= line_q[i+1];
        end
      end
    end
  end

endmodule

FILE: rtl/core/gtm_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtm_emit
// Scales point coordinates by the tile size and drives the point output.
// ----------------------------------------------------------------------------
module gtm_emit #(
  parameter int CW = 8,
  parameter int RW = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [gtm_pkg::SIZE_W-1:0]   tile_size,
  input  logic                         pt_valid,
  output logic                         pt_ready,
  input  logic [CW-1:0]                pt_x,
  input  logic [RW-1:0]                pt_y,
  input  gtm_pkg::point_tag_t          pt_tag,
  output logic                         point_valid,
  input  logic                         point_stall,
  output logic [gtm_pkg::COORD_W-1:0]  cell_x,
  output logic [gtm_pkg::COORD_W-1:0]  cell_y,
  output logic                         is_large,
  output logic [gtm_pkg::WORLD_W-1:0]  world_x_half,
  output logic [gtm_pkg::WORLD_W-1:0]  world_y_half,
  output logic [gtm_pkg::EXTENT_W-1:0] extent_half,
  output logic                         last
);

  import gtm_pkg::*;

  localparam int PXW = CW + 1 + SIZE_W;
  localparam int PYW = RW + 1 + SIZE_W;
  localparam int EXW = (PXW > WORLD_W) ? PXW : WORLD_W;
  localparam int EYW = (PYW > WORLD_W) ? PYW : WORLD_W;

  logic          m_valid;
  logic [CW-1:0] mx;
  logic [RW-1:0] my;
  point_tag_t    mtag;
  logic          out_free;
  logic          m_ready;
  logic [EXW-1:0] px;
  logic [EYW-1:0] py;

  assign out_free = !point_valid || !point_stall;
  assign m_ready  = !m_valid || out_free;
  assign pt_ready = m_ready;

  // Position in half units: 2x*size, or (2x+1)*size for a merged block
  assign px = EXW'({mx, mtag.merged}) * EXW'(tile_size);
  assign py = EYW'({my, mtag.merged}) * EYW'(tile_size);

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid     <= 1'b0;
      point_valid <= 1'b0;
    end else begin
      if (m_ready)  m_valid     <= pt_valid;
      if (out_free) point_valid <= m_valid;
    end
  end

  // Operand stage
  always_ff @(posedge clk) begin
    if (pt_valid && m_ready) begin
      mx   <= pt_x;
      my   <= pt_y;
      mtag <= pt_tag;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (m_valid && out_free) begin
      cell_x       <= COORD_W'(mx);
      cell_y       <= COORD_W'(my);
      is_large     <= mtag.merged;
      world_x_half <= px[WORLD_W-1:0];
      world_y_half <= py[WORLD_W-1:0];
      extent_half  <= mtag.merged ? {tile_size, 1'b0} : {1'b0, tile_size};
      last         <= mtag.last;
    end
  end

endmodule

FILE: rtl/core/greedy_2x2_tile_merge_unit.sv
// Path: queue, sequencer, operand stage and output register; a cell is
// decided one row and one column late. Throughput: one tile per cycle while
// each tile yields at most one point and the output does not stall; a tile
// with several points holds the sequencer until its last point is issued.
// Reset: synchronous; clears counters, queue and pipeline, loads defaults.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_2x2_tile_merge_unit
// Streams grid tiles in raster order and emits single or merged 2x2 points.
// ----------------------------------------------------------------------------
module greedy_2x2_tile_merge_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  gtm_pkg::cfg_index_t          cfg_index,
  input  logic [gtm_pkg::CFG_W-1:0]    cfg_data,
  // tiles
  input  logic                         tile_valid,
  output logic                         tile_stall,
  input  logic [gtm_pkg::TYPE_W-1:0]   tile_type,
  // points
  output logic                         point_valid,
  input  logic                         point_stall,
  output logic [gtm_pkg::COORD_W-1:0]  cell_x,
  output logic [gtm_pkg::COORD_W-1:0]  cell_y,
  output logic                         is_large,
  output logic [gtm_pkg::WORLD_W-1:0]  world_x_half,
  output logic [gtm_pkg::WORLD_W-1:0]  world_y_half,
  output logic [gtm_pkg::EXTENT_W-1:0] extent_half,
  output logic                         last
);

  import gtm_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int GWW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam int GHW = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;
  localparam int CLS_W = $bits(tile_class_t);
  localparam int QW  = CW + RW + CLS_W;

  // Configuration registers
  logic [TYPE_W-1:0] target_type;
  logic [DIM_W-1:0]  grid_width;
  logic [DIM_W-1:0]  grid_height;
  logic [SIZE_W-1:0] tile_size;
  logic              cfg_wr;
  logic              restart;

  // Clamped geometry, minus one
  logic [GWW-1:0] gw_ext;
  logic [GHW-1:0] gh_ext;
  logic [CW-1:0]  wm1;
  logic [RW-1:0]  hm1;

  // Front to queue to back
  logic          f_push_valid;
  logic          f_push_ready;
  logic [CW-1:0] f_col;
  logic [RW-1:0] f_row;
  tile_class_t   f_cls;
  logic [QW-1:0] q_in;
  logic [QW-1:0] q_out;
  logic          q_valid;
  logic          q_ready;
  logic [CW-1:0] b_col;
  logic [RW-1:0] b_row;
  tile_class_t   b_cls;

  // Back to emit
  logic          pt_valid;
  logic          pt_ready;
  logic [CW-1:0] pt_x;
  logic [RW-1:0] pt_y;
  point_tag_t    pt_tag;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign restart   = cfg_wr &&
                     ((cfg_index == CFG_GRID_WIDTH) || (cfg_index == CFG_GRID_HEIGHT));

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_type <= RST_TARGET_TYPE;
      grid_width  <= RST_GRID_DIM;
      grid_height <= RST_GRID_DIM;
      tile_size   <= RST_TILE_SIZE;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_TARGET_TYPE: target_type <= cfg_data[TYPE_W-1:0];
        CFG_GRID_WIDTH:  grid_width  <= cfg_data[DIM_W-1:0];
        CFG_GRID_HEIGHT: grid_height <= cfg_data[DIM_W-1:0];
        CFG_TILE_SIZE:   tile_size   <= cfg_data[SIZE_W-1:0];
        default:         target_type <= target_type;
      endcase
    end
  end

  // Zero counts as one, large values saturate
  always_comb begin
    gw_ext = GWW'(grid_width);
    gh_ext = GHW'(grid_height);
    if (gw_ext == '0) wm1 = '0;
    else if (gw_ext > GWW'(MAX_WIDTH)) wm1 = CW'(MAX_WIDTH - 1);
    else wm1 = CW'(gw_ext - GWW'(1));
    if (gh_ext == '0) hm1 = '0;
    else if (gh_ext > GHW'(MAX_HEIGHT)) hm1 = RW'(MAX_HEIGHT - 1);
    else hm1 = RW'(gh_ext - GHW'(1));
  end

  gtm_front #(
    .CW (CW),
    .RW (RW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .target_type (target_type),
    .wm1         (wm1),
    .hm1         (hm1),
    .tile_valid  (tile_valid),
    .tile_stall  (tile_stall),
    .tile_type   (tile_type),
    .push_valid  (f_push_valid),
    .push_ready  (f_push_ready),
    .col         (f_col),
    .row         (f_row),
    .cls         (f_cls)
  );

  assign q_in = {f_col, f_row, f_cls};

  gtm_queue #(
    .DW (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_push_valid),
    .push_ready (f_push_ready),
    .push_data  (q_in),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_out)
  );

  assign {b_col, b_row, b_cls} = q_out;

  gtm_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW),
    .RW        (RW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wm1       (wm1),
    .ent_valid (q_valid),
    .ent_ready (q_ready),
    .ent_col   (b_col),
    .ent_row   (b_row),
    .ent_cls   (b_cls),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .pt_x      (pt_x),
    .pt_y      (pt_y),
    .pt_tag    (pt_tag)
  );

  gtm_emit #(
    .CW (CW),
    .RW (RW)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .tile_size    (tile_size),
    .pt_valid     (pt_valid),
    .pt_ready     (pt_ready),
    .pt_x         (pt_x),
    .pt_y         (pt_y),
    .pt_tag       (pt_tag),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .is_large     (is_large),
    .world_x_half (world_x_half),
    .world_y_half (world_y_half),
    .extent_half  (extent_half),
    .last         (last)
  );

`ifndef SYNTHESIS
  // Raster position stays inside the configured grid
  a_col_in_grid: assert property (@(posedge clk) disable iff (rst) f_col <= wm1)
    else $error("column counter beyond grid width");
  a_row_in_grid: assert property (@(posedge clk) disable iff (rst) f_row <= hm1)
    else $error("row counter beyond grid height");
  // A geometry write restarts the grid at the top-left cell
  a_restart: assert property (@(posedge clk) disable iff (rst)
    restart |=> (f_col == '0) && (f_row == '0))
    else $error("grid not restarted after geometry write");
`endif

endmodule

FILE: verif/greedy_2x2_tile_merge_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_2x2_tile_merge_unit_tb
// Streams directed and random tile grids through the merge unit under
// varying back-pressure and checks every point against a scan predictor.
// ----------------------------------------------------------------------------
module greedy_2x2_tile_merge_unit_tb;
  import gtm_pkg::*;

  localparam int MAXW         = 256;
  localparam int MAXH         = 256;
  localparam int SETTLE       = 12;   // cycles past the last point before a write
  localparam int RANDOM_ITEMS = 146;

  // One point as seen on the output port
  typedef struct packed {
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic                merged;
    logic [WORLD_W-1:0]  wx;
    logic [WORLD_W-1:0]  wy;
    logic [EXTENT_W-1:0] ext;
    logic                last_flag;
  } point_t;

  // Scan predictor plus queue of points still to arrive
  class merge_scoreboard;
    logic [TYPE_W-1:0] target;
    logic [DIM_W-1:0]  gw;
    logic [DIM_W-1:0]  gh;
    logic [SIZE_W-1:0] tsize;
    int                col;
    int                row;
    bit [MAXW-1:0]     up_m, up_v, lo_m, lo_v;
    point_t            expected_points[$];
    point_t            batch[$];
    int                errors;

    function new();
      target = RST_TARGET_TYPE;
      gw     = RST_GRID_DIM;
      gh     = RST_GRID_DIM;
      tsize  = RST_TILE_SIZE;
      errors = 0;
      restart();
    endfunction

    function void restart();
      col  = 0;
      row  = 0;
      up_m = '0;
      up_v = '0;
      lo_m = '0;
      lo_v = '0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] d);
      case (idx)
        CFG_TARGET_TYPE: target = d[TYPE_W-1:0];
        CFG_GRID_WIDTH: begin
          gw = d[DIM_W-1:0];
          restart();
        end
        CFG_GRID_HEIGHT: begin
          gh = d[DIM_W-1:0];
          restart();
        end
        CFG_TILE_SIZE: tsize = d[SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    // zero counts as one, oversize saturates
    function int span(logic [DIM_W-1:0] v, int maxv);
      if (v == 0) return 1;
      return (int'(v) > maxv) ? maxv : int'(v);
    endfunction

    function void add_point(int x, int y, bit merged);
      point_t p;
      longint s, wx, wy, ext;
      s   = tsize;
      wx  = merged ? (2 * x + 1) * s : 2 * x * s;
      wy  = merged ? (2 * y + 1) * s : 2 * y * s;
      ext = merged ? 2 * s : s;
      p.cx        = x[COORD_W-1:0];
      p.cy        = y[COORD_W-1:0];
      p.merged    = merged;
      p.wx        = wx[WORLD_W-1:0];
      p.wy        = wy[WORLD_W-1:0];
      p.ext       = ext[EXTENT_W-1:0];
      p.last_flag = 1'b0;
      batch.push_back(p);
    endfunction

    // cell of the row above, may merge right and down
    function void decide_upper_cell(int x, int y, bit has_right);
      int n;
      n = x + 1;
      if (up_v[x] || !up_m[x]) return;
      if (has_right && n < MAXW && up_m[n] && !up_v[n] &&
          lo_m[x] && !lo_v[x] && lo_m[n] && !lo_v[n]) begin
        up_v[x] = 1'b1;
        up_v[n] = 1'b1;
        lo_v[x] = 1'b1;
        lo_v[n] = 1'b1;
        add_point(x, y, 1'b1);
      end else begin
        up_v[x] = 1'b1;
        add_point(x, y, 1'b0);
      end
    endfunction

    // cell of the last row, single only
    function void decide_bottom_cell(int x, int y);
      if (lo_v[x] || !lo_m[x]) return;
      lo_v[x] = 1'b1;
      add_point(x, y, 1'b0);
    endfunction

    function void note_tile(logic [TYPE_W-1:0] t);
      int w, h, c, r;
      bit row_end, last_row;
      w = span(gw, MAXW);
      h = span(gh, MAXH);
      c = (col >= w) ? w - 1 : col;
      r = (row >= h) ? h - 1 : row;
      row_end  = (c == w - 1);
      last_row = (r == h - 1);
      batch.delete();
      lo_m[c] = (t == target);
      if (r > 0) begin
        if (c > 0) decide_upper_cell(c - 1, r - 1, 1'b1);
        if (row_end) decide_upper_cell(c, r - 1, 1'b0);
      end
      if (last_row) begin
        if (c > 0) decide_bottom_cell(c - 1, r);
        if (row_end) decide_bottom_cell(c, r);
      end
      // advance raster position, rotate or clear rows
      if (row_end) begin
        col = 0;
        if (last_row) begin
          restart();
        end else begin
          row  = r + 1;
          up_m = lo_m;
          up_v = lo_v;
          lo_m = '0;
          lo_v = '0;
        end
      end else begin
        col = c + 1;
        row = r;
      end
      if (batch.size() > 0) batch[batch.size() - 1].last_flag = 1'b1;
      foreach (batch[i]) expected_points.push_back(batch[i]);
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected point, expected none actual cell (%0d,%0d)",
                 $time, got.cx, got.cy);
        return;
      end
      want = expected_points.pop_front();
      compare_field("cell_x", want.cx, got.cx);
      compare_field("cell_y", want.cy, got.cy);
      compare_field("is_large", want.merged, got.merged);
      compare_field("world_x_half", want.wx, got.wx);
      compare_field("world_y_half", want.wy, got.wy);
      compare_field("extent_half", want.ext, got.ext);
      compare_field("last", want.last_flag, got.last_flag);
    endfunction
  endclass

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  cfg_index_t           cfg_index   = CFG_TARGET_TYPE;
  logic [CFG_W-1:0]     cfg_data    = '0;
  logic                 tile_valid  = 1'b0;
  logic                 tile_stall;
  logic [TYPE_W-1:0]    tile_type   = '0;
  logic                 point_valid;
  logic                 point_stall = 1'b0;
  logic [COORD_W-1:0]   cell_x;
  logic [COORD_W-1:0]   cell_y;
  logic                 is_large;
  logic [WORLD_W-1:0]   world_x_half;
  logic [WORLD_W-1:0]   world_y_half;
  logic [EXTENT_W-1:0]  extent_half;
  logic                 last;

  int send_idle = 18;
  int recv_idle = 58;

  merge_scoreboard sb = new();

  greedy_2x2_tile_merge_unit #(
    .MAX_WIDTH  (MAXW),
    .MAX_HEIGHT (MAXH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tile_valid   (tile_valid),
    .tile_stall   (tile_stall),
    .tile_type    (tile_type),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .is_large     (is_large),
    .world_x_half (world_x_half),
    .world_y_half (world_y_half),
    .extent_half  (extent_half),
    .last         (last)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Point receiver: check each transfer, stall at random
  always @(posedge clk) begin
    if (!rst && point_valid && !point_stall)
      sb.check_point('{cell_x, cell_y, is_large, world_x_half, world_y_half,
                       extent_half, last});
    point_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  // One tile transfer, with a random gap in front
  task automatic send_tile(input logic [TYPE_W-1:0] t);
    while ($urandom_range(0, 99) < send_idle) begin
      tile_valid <= 1'b0;
      @(posedge clk);
    end
    tile_valid <= 1'b1;
    tile_type  <= t;
    @(posedge clk);
    while (tile_stall) @(posedge clk);
    sb.note_tile(t);
  endtask

  // Hold tiles back until every point is out and the pipeline is empty
  task automatic wait_idle();
    tile_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write; caller lowers cfg_valid after the last one
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic setup_grid(input logic [CFG_W-1:0] tt, input logic [CFG_W-1:0] w,
                            input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] s);
    wait_idle();
    write_reg(CFG_TARGET_TYPE, tt);
    write_reg(CFG_GRID_WIDTH, w);
    write_reg(CFG_GRID_HEIGHT, h);
    write_reg(CFG_TILE_SIZE, s);
    cfg_valid <= 1'b0;
  endtask

  // Target type with the given percentage, otherwise any type
  function automatic logic [TYPE_W-1:0] pick_tile(int pct);
    if ($urandom_range(0, 99) < pct) return sb.target;
    return TYPE_W'($urandom_range(0, 255));
  endfunction

  // Stimulus
  initial begin
    int done;
    int w, h, n, pct;
    logic [CFG_W-1:0] s;
    done = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: start of a 256-wide grid, no point yet
    repeat (3) send_tile(8'h00);
    // 2x2 at maximum type and size: one merged point
    setup_grid(16'h00FF, 16'd2, 16'd2, 16'hFFFF);
    repeat (4) send_tile(8'hFF);
    // zero dimensions count as one, zero size gives zero geometry
    setup_grid(16'h0000, 16'd0, 16'd0, 16'd0);
    send_tile(8'h00);
    send_tile(8'h01);
    send_tile(8'h00);
    // 3x2 with a gap in the top row: several points from one tile
    setup_grid(16'h005A, 16'd3, 16'd2, 16'd1);
    send_tile(8'h5A);
    send_tile(8'h00);
    send_tile(8'h5A);
    repeat (3) send_tile(8'h5A);
    // oversize dimensions saturate; the next geometry write restarts the grid
    setup_grid(16'h0033, 16'd511, 16'd300, 16'd7);
    repeat (2) send_tile(8'h33);
    // target changes mid-grid, after all points are out
    setup_grid(16'h0007, 16'd2, 16'd3, 16'd3);
    repeat (2) send_tile(8'h07);
    wait_idle();
    write_reg(CFG_TARGET_TYPE, 16'h0009);
    cfg_valid <= 1'b0;
    repeat (3) send_tile(8'h09);
    send_tile(8'h00);

    // random grids, mostly whole, some cut short, some run twice
    while (done < RANDOM_ITEMS) begin
      if (done < RANDOM_ITEMS / 3) begin
        send_idle = 18;
        recv_idle = 58;
      end else if (done < 2 * RANDOM_ITEMS / 3) begin
        send_idle = 58;
        recv_idle = 18;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      h = $urandom_range(1, 5);
      case ($urandom_range(0, 4))
        0: s = 16'd1;
        1: s = 16'hFFFF;
        2: s = 16'd0;
        default: s = CFG_W'($urandom_range(1, 65535));
      endcase
      setup_grid(CFG_W'($urandom_range(0, 255)), CFG_W'(w), CFG_W'(h), s);
      n = w * h;
      case ($urandom_range(0, 5))
        0: n = $urandom_range(1, n);
        1: n = 2 * n;
        default: ;
      endcase
      // keep the total close to the item budget
      if (n > RANDOM_ITEMS - done) n = RANDOM_ITEMS - done;
      pct = $urandom_range(45, 95);
      for (int i = 0; i < n; i++) begin
        send_tile(pick_tile(pct));
        if (i == n / 2 && $urandom_range(0, 3) == 0) wait_idle();
      end
      done += n;
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
